[rtl/core/csf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_pkg: shared constants, types and hash helpers
// Register indexes, hash modes, states, the config type and a rotate helper.
// ----------------------------------------------------------------------------
package csf_pkg;

  localparam int unsigned Units     = 65536;
  localparam int unsigned UnitW     = (Units > 1) ? $clog2(Units) : 1;
  localparam int unsigned SlotW     = 16;

  typedef enum logic [1:0] {
    REG_HASH_MODE    = 2'd0,
    REG_COUPON_COUNT = 2'd1,
    REG_COUPON_STEP  = 2'd2,
    REG_HASH_SEED    = 2'd3
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_RANDOM = 2'd0,
    MODE_ELEM   = 2'd1,
    MODE_ELEM8  = 2'd2,
    MODE_SPARE  = 2'd3
  } hash_mode_e;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WRITE
  } state_e;

  typedef struct packed {
    logic [1:0]  hash_mode;
    logic [3:0]  coupon_count;
    logic [31:0] coupon_step;
    logic [31:0] hash_seed;
  } cfg_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
    rotl32 = (x << r) | (x >> (32 - r));
  endfunction

endpackage
`default_nettype wire

[rtl/core/csf_hash.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_hash: sequential MurmurHash3 unit
// Computes the coupon hash and the unit index, one multiply per cycle.
// ----------------------------------------------------------------------------
module csf_hash (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire csf_pkg::cfg_t             cfg_i,
  input  wire logic [31:0]               flow_i,
  input  wire logic [31:0]               elem_i,
  input  wire logic [31:0]               rnd_i,
  output logic                           done_o,
  output logic [31:0]                    coupon_hash_o,
  output logic [csf_pkg::UnitW-1:0]      unit_idx_o
);

  // micro-op program counter
  logic [5:0]  pc_q, pc_d;
  logic        busy_q, busy_d;
  logic [31:0] a_q, a_d, b_q, b_d, k_q, k_d, h_q, h_d;
  logic [31:0] w1_q, w1_d, w2_q, w2_d;
  logic [1:0]  n_q, n_d;
  logic [1:0]  wi_q, wi_d;
  logic [63:0] full128;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= '0;
      busy_q <= 1'b0;
    end else begin
      pc_q <= pc_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d; b_q <= b_d;
    k_q <= k_d; h_q <= h_d; w1_q <= w1_d; w2_q <= w2_d;
    n_q <= n_d; wi_q <= wi_d;
  end

  // One step per cycle; pc 0..6 does the 32-bit hash, 16..29 the 128-bit hash.
  // The element and random words are taken from the request at start.
  always_comb begin
    logic [31:0] w;
    pc_d = pc_q; busy_d = busy_q;
    a_d = a_q; b_d = b_q; k_d = k_q; h_d = h_q;
    w1_d = w1_q; w2_d = w2_q; n_d = n_q; wi_d = wi_q;
    done_o = 1'b0;
    w = (wi_q == 2'd0) ? flow_i : (wi_q == 2'd1) ? w1_q : w2_q;
    if (!busy_q) begin
      if (start_i) begin
        busy_d = 1'b1;
        pc_d = 6'd0;
        h_d = cfg_i.hash_seed;
        wi_d = 2'd0;
        unique case (csf_pkg::hash_mode_e'(cfg_i.hash_mode))
          csf_pkg::MODE_RANDOM: begin w1_d = rnd_i; n_d = 2'd2; end
          csf_pkg::MODE_ELEM8: begin w1_d = '0; w2_d = elem_i; n_d = 2'd3; end
          default: begin w1_d = elem_i; n_d = 2'd2; end
        endcase
      end
    end else begin
      pc_d = pc_q + 6'd1;
      unique case (pc_q)
        6'd0: k_d = w * 32'hcc9e2d51;
        6'd1: k_d = csf_pkg::rotl32(k_q, 15) * 32'h1b873593;
        6'd2: begin
          h_d = csf_pkg::rotl32(h_q ^ k_q, 13) * 32'd5 + 32'he6546b64;
          wi_d = wi_q + 2'd1;
          if (wi_q + 2'd1 != n_q) pc_d = 6'd0;
        end
        6'd3: begin
          h_d = h_q ^ {28'd0, n_q, 2'b00};
          h_d = h_d ^ (h_d >> 16);
        end
        6'd4: h_d = h_q * 32'h85ebca6b;
        6'd5: h_d = (h_q ^ (h_q >> 13)) * 32'hc2b2ae35;
        6'd6: begin h_d = h_q ^ (h_q >> 16); pc_d = 6'd16; end
        // 128-bit flow hash
        6'd16: k_d = flow_i * 32'h239b961b;
        6'd17: k_d = csf_pkg::rotl32(k_q, 15) * 32'hab0e9385;
        6'd18: begin
          a_d = (cfg_i.hash_seed ^ k_q) ^ 32'd9;
          b_d = cfg_i.hash_seed ^ 32'd9;
        end
        6'd19: a_d = a_q + b_q + b_q + b_q;
        6'd20: b_d = b_q + a_q;
        // fmix on a and b (the third and fourth lanes equal b)
        6'd21: begin a_d = a_q ^ (a_q >> 16); b_d = b_q ^ (b_q >> 16); end
        6'd22: a_d = a_q * 32'h85ebca6b;
        6'd23: b_d = b_q * 32'h85ebca6b;
        6'd24: begin a_d = a_q ^ (a_q >> 13); b_d = b_q ^ (b_q >> 13); end
        6'd25: a_d = a_q * 32'hc2b2ae35;
        6'd26: b_d = b_q * 32'hc2b2ae35;
        6'd27: begin a_d = a_q ^ (a_q >> 16); b_d = b_q ^ (b_q >> 16); end
        6'd28: a_d = a_q + b_q + b_q + b_q;
        6'd29: begin b_d = b_q + a_q; busy_d = 1'b0; done_o = 1'b1; end
        default: ;
      endcase
    end
  end

  assign full128 = {b_q + a_q, a_q};
  assign coupon_hash_o = h_q;
  assign unit_idx_o = full128[csf_pkg::UnitW-1:0];

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_q) else $error("done without busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy_q) else $error("busy after done");
  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (pc_q < 6'd30)) else $error("pc out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/csf_store.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csf_store: coupon unit memory
// One-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module csf_store (
  input  wire logic                      clk_i,
  input  wire logic                      we_i,
  input  wire logic [csf_pkg::UnitW-1:0] addr_i,
  input  wire logic [7:0]                wdata_i,
  output logic [7:0]                     rdata_o
);

  logic [7:0] mem_q [csf_pkg::Units];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end

endmodule
`default_nettype wire

[rtl/core/coupon_spread_filter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// coupon_spread_filter: coupon filter ahead of a spread sketch
// Hashes flow with element or random word, draws a coupon and updates its unit.
// ----------------------------------------------------------------------------
// After reset the unit store is cleared one entry per cycle, all Units
// entries, with the input stalled. Each request then holds the input until
// its write-back: the request is taken, then the shared hash unit runs the
// MurmurHash3 steps one multiply per cycle (on three words in hash mode 2,
// two otherwise) while the unit memory read is issued, and then the entry
// is written back and the output register loaded in the same cycle. The
// write-back waits while an earlier result still sits stalled in the output
// register; the next request is taken only after the write-back, while
// that result may still wait in the output register.
module coupon_spread_filter (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] flow_key_i,
  input  wire logic [31:0] element_key_i,
  input  wire logic [31:0] random_word_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             forward_to_sketch_o,
  output logic [31:0]      flow_out_o,
  output logic [31:0]      element_out_o,
  output logic [15:0]      unit_slot_o,
  output logic             coupon_hit_o,
  output logic [2:0]       coupon_drawn_o,
  output logic [7:0]       unit_bits_o
);

  localparam int unsigned UW = csf_pkg::UnitW;

  csf_pkg::cfg_t    cfg_q;
  csf_pkg::state_e  state_q, state_d;
  logic [UW-1:0]    clr_q, clr_d;
  logic [31:0]      flow_q, elem_q;
  logic [UW-1:0]    idx_q;
  logic             hit_q;
  logic [2:0]       drawn_q;
  logic             hstart, hdone;
  logic [31:0]      chash;
  logic [UW-1:0]    hidx;
  logic             mem_we;
  logic [UW-1:0]    mem_addr;
  logic [7:0]       mem_wdata, mem_rdata, new_bits;
  logic [3:0]       cnt;
  logic [7:0]       mask;
  logic             accept, out_load;
  logic             hit_c;
  logic [2:0]       drawn_c;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.hash_mode    <= 2'd1;
      cfg_q.coupon_count <= 4'd4;
      cfg_q.coupon_step  <= 32'd429496729;
      cfg_q.hash_seed    <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (csf_pkg::reg_idx_e'(cfg_idx_i))
        csf_pkg::REG_HASH_MODE:    cfg_q.hash_mode <= cfg_data_i[1:0];
        csf_pkg::REG_COUPON_COUNT: cfg_q.coupon_count <= cfg_data_i[3:0];
        csf_pkg::REG_COUPON_STEP:  cfg_q.coupon_step <= cfg_data_i;
        csf_pkg::REG_HASH_SEED:    cfg_q.hash_seed <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cnt = (cfg_q.coupon_count == 4'd0) ? 4'd1 :
               (cfg_q.coupon_count > 4'd8) ? 4'd8 : cfg_q.coupon_count;
  assign mask = 8'((9'd1 << cnt) - 9'd1);

  // first coupon whose bound exceeds the hash
  always_comb begin
    logic [35:0] bound;
    hit_c = 1'b0;
    drawn_c = '0;
    bound = '0;
    for (int i = 0; i < 8; i++) begin
      bound = bound + {4'd0, cfg_q.coupon_step};
      if (!hit_c && (i < int'(cnt)) && ({4'd0, chash} < bound)) begin
        hit_c = 1'b1;
        drawn_c = 3'(i);
      end
    end
  end

  assign accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != csf_pkg::ST_IDLE);
  assign hstart = accept;
  assign new_bits = mem_rdata | (hit_q ? (8'd1 << drawn_q) : 8'd0);
  // write-back and result load happen once the output register is free
  assign out_load = (state_q == csf_pkg::ST_WRITE) && (!out_valid_o || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csf_pkg::ST_CLEAR;
      clr_q <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q <= clr_d;
      if (out_load) out_valid_o <= 1'b1;
      else if (!out_stall_i) out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      flow_q <= flow_key_i; elem_q <= element_key_i;
    end
    if (hdone) begin
      idx_q <= hidx; hit_q <= hit_c; drawn_q <= drawn_c;
    end
    if (out_load) begin
      forward_to_sketch_o <= (new_bits & mask) == mask;
      flow_out_o <= flow_q;
      element_out_o <= elem_q;
      unit_slot_o <= 16'({{(32-UW){1'b0}}, idx_q});
      coupon_hit_o <= hit_q;
      coupon_drawn_o <= drawn_q;
      unit_bits_o <= new_bits;
    end
  end

  // sequencer: clear pass, wait for hash, read, write back
  always_comb begin
    state_d = state_q;
    clr_d = clr_q;
    mem_we = 1'b0;
    mem_addr = idx_q;
    mem_wdata = new_bits;
    unique case (state_q)
      csf_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        mem_addr = clr_q;
        mem_wdata = '0;
        clr_d = clr_q + UW'(1);
        if (clr_q == UW'(csf_pkg::Units - 1)) state_d = csf_pkg::ST_IDLE;
      end
      csf_pkg::ST_IDLE: if (accept) state_d = csf_pkg::ST_READ;
      csf_pkg::ST_READ: begin
        mem_addr = hidx;
        if (hdone) state_d = csf_pkg::ST_WRITE;
      end
      csf_pkg::ST_WRITE: begin
        if (out_load) begin
          mem_we = 1'b1;
          state_d = csf_pkg::ST_IDLE;
        end
      end
      default: state_d = csf_pkg::ST_IDLE;
    endcase
  end

  csf_hash u_hash (
    .clk_i, .rst_ni,
    .start_i(hstart), .cfg_i(cfg_q),
    .flow_i(flow_q), .elem_i(element_key_i), .rnd_i(random_word_i),
    .done_o(hdone), .coupon_hash_o(chash), .unit_idx_o(hidx)
  );

  csf_store u_store (
    .clk_i, .we_i(mem_we), .addr_i(mem_addr), .wdata_i(mem_wdata), .rdata_o(mem_rdata)
  );

`ifndef SYNTHESIS
  a_no_accept_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csf_pkg::ST_CLEAR) |-> in_stall_o) else $error("accept during clear");
  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == csf_pkg::ST_WRITE && mem_we) |=> state_q == csf_pkg::ST_IDLE)
    else $error("write-back did not finish");
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load && mem_we |=> out_valid_o) else $error("result lost");
`endif

endmodule
`default_nettype wire

[verif/tb_coupon_spread_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_coupon_spread_filter: self-checking bench for the coupon filter
// Drives flow/element requests under several register settings. A local
// model of the hashes and the coupon store predicts every result, and each
// result is compared field by field as it leaves the block.
// ----------------------------------------------------------------------------
module tb_coupon_spread_filter;

  localparam int unsigned StallLimit = 200000;  // covers the store clear pass
  localparam int unsigned SettleCyc  = 60;      // longer than the longest request
  localparam int unsigned HoldCyc    = 400;

  typedef struct packed {
    logic        fwd;
    logic [31:0] flow;
    logic [31:0] elem;
    logic [15:0] slot;
    logic        hit;
    logic [2:0]  drawn;
    logic [7:0]  bits;
  } coupon_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = csf_pkg::REG_HASH_MODE;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [31:0] flow_key_i = '0;
  logic [31:0] element_key_i = '0;
  logic [31:0] random_word_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic        forward_to_sketch_o;
  logic [31:0] flow_out_o;
  logic [31:0] element_out_o;
  logic [15:0] unit_slot_o;
  logic        coupon_hit_o;
  logic [2:0]  coupon_drawn_o;
  logic [7:0]  unit_bits_o;

  coupon_spread_filter dut (.*);

  // shadow of the block's registers and coupon store
  logic [1:0]  mode_q;
  logic [3:0]  count_q;
  logic [31:0] step_q;
  logic [31:0] seed_q;
  logic [7:0]  unit_store [csf_pkg::Units];

  coupon_result_t pending_results[$];
  int unsigned    mismatches = 0;
  bit             steady = 1'b0;     // no idling on either side
  bit             hold_req = 1'b0;
  int unsigned    hold_left = 0;
  logic [31:0]    flow_pool [8];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------- hashing
  function automatic logic [31:0] rot_left(logic [31:0] x, int unsigned r);
    return (x << r) | (x >> (32 - r));
  endfunction

  function automatic logic [31:0] final_mix(logic [31:0] h);
    h ^= h >> 16;
    h *= 32'h85ebca6b;
    h ^= h >> 13;
    h *= 32'hc2b2ae35;
    h ^= h >> 16;
    return h;
  endfunction

  function automatic logic [31:0] companion_hash(logic [31:0] w0, logic [31:0] w1,
                                                 logic [31:0] w2, int unsigned n);
    logic [31:0] words [3];
    logic [31:0] h, k;
    words = '{w0, w1, w2};
    h = seed_q;
    for (int i = 0; i < n; i++) begin
      k = rot_left(words[i] * 32'hcc9e2d51, 15) * 32'h1b873593;
      h = rot_left(h ^ k, 13) * 32'd5 + 32'he6546b64;
    end
    return final_mix(h ^ (n * 4));
  endfunction

  // low word of the 128-bit flow hash; Units divides 2^32 so this picks the unit
  function automatic logic [31:0] flow_unit_hash(logic [31:0] flow);
    logic [31:0] a, b, c, d;
    a = seed_q ^ (rot_left(flow * 32'h239b961b, 15) * 32'hab0e9385);
    b = seed_q ^ 32'd9;
    c = b;
    d = b;
    a ^= 32'd9;
    a = a + b + c + d;
    b += a; c += a; d += a;
    a = final_mix(a); b = final_mix(b); c = final_mix(c); d = final_mix(d);
    return a + b + c + d;
  endfunction

  function automatic coupon_result_t predict_coupon(logic [31:0] flow, logic [31:0] elem,
                                                    logic [31:0] rnd);
    coupon_result_t r;
    logic [31:0] ch;
    int unsigned cnt, slot;
    logic [7:0]  mask;
    cnt = (count_q < 1) ? 1 : (count_q > 8) ? 8 : count_q;
    case (csf_pkg::hash_mode_e'(mode_q))
      csf_pkg::MODE_RANDOM: ch = companion_hash(flow, rnd, 32'd0, 2);
      csf_pkg::MODE_ELEM8:  ch = companion_hash(flow, 32'd0, elem, 3);
      default:              ch = companion_hash(flow, elem, 32'd0, 2);
    endcase
    slot = flow_unit_hash(flow) % csf_pkg::Units;
    r = '0;
    for (int i = 0; i < cnt; i++) begin
      if (!r.hit && {4'd0, ch} < 36'(i + 1) * {4'd0, step_q}) begin
        r.hit = 1'b1;
        r.drawn = 3'(i);
      end
    end
    if (r.hit) unit_store[slot] |= 8'(1 << r.drawn);
    mask = 8'((9'd1 << cnt) - 9'd1);
    r.bits = unit_store[slot];
    r.fwd = (r.bits & mask) == mask;
    r.flow = flow;
    r.elem = elem;
    r.slot = 16'(slot);
    return r;
  endfunction

  // ---------------------------------------------------------------- driving
  task automatic write_reg(csf_pkg::reg_idx_e idx, logic [31:0] value);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = value;
    @(posedge clk_i);
    case (idx)
      csf_pkg::REG_HASH_MODE:    mode_q = value[1:0];
      csf_pkg::REG_COUPON_COUNT: count_q = value[3:0];
      csf_pkg::REG_COUPON_STEP:  step_q = value;
      default:                   seed_q = value;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic set_config(logic [1:0] mode, logic [3:0] cnt, logic [31:0] step,
                            logic [31:0] seed);
    write_reg(csf_pkg::REG_HASH_MODE, {30'd0, mode});
    write_reg(csf_pkg::REG_COUPON_COUNT, {28'd0, cnt});
    write_reg(csf_pkg::REG_COUPON_STEP, step);
    write_reg(csf_pkg::REG_HASH_SEED, seed);
  endtask

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_request(logic [31:0] flow, logic [31:0] elem, logic [31:0] rnd);
    if (!steady && $urandom_range(0, 99) < 37) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    flow_key_i = flow;
    element_key_i = elem;
    random_word_i = rnd;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(predict_coupon(flow, elem, rnd));
    @(negedge clk_i);
  endtask

  // all results back, then room for the pipeline to empty before a register write
  task automatic settle();
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------- receiving
  always @(negedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldCyc;
      hold_req = 1'b0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall_i = 1'b1;
    end else begin
      out_stall_i = !steady && ($urandom_range(0, 99) < 37);
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    coupon_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("result with no request pending: flow %h", flow_out_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("forward_to_sketch", want.fwd, forward_to_sketch_o);
        check_field("flow_out", want.flow, flow_out_o);
        check_field("element_out", want.elem, element_out_o);
        check_field("unit_slot", want.slot, unit_slot_o);
        check_field("coupon_hit", want.hit, coupon_hit_o);
        check_field("coupon_drawn", want.drawn, coupon_drawn_o);
        check_field("unit_bits", want.bits, unit_bits_o);
      end
    end
  end

  // watchdog: cycles without any handshake
  int unsigned quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- tests
  // reset values, field extremes, store clear pass absorbed by the stall
  task automatic test_reset_defaults();
    send_request(32'h0, 32'h0, 32'h0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'h0000_0001, 32'h5555_5555);
    send_request(32'h0000_0001, 32'hAAAA_AAAA, 32'hAAAA_AAAA);
    settle();
  endtask

  // every hash mode, the spare one included
  task automatic test_hash_modes();
    for (int m = 0; m < 4; m++) begin
      set_config(2'(m), 4'd4, 32'h3333_3333, 32'h1234_5678);
      send_request(32'hDEAD_BEEF, 32'h0BAD_F00D, 32'h1357_9BDF);
      send_request(32'hDEAD_BEEF, 32'hFFFF_FFFF, 32'h0);
      settle();
    end
  endtask

  // step extremes, coupon counts out of range, lowered count leaves high bits
  task automatic test_coupon_edges();
    set_config(csf_pkg::MODE_ELEM, 4'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h0000_00AA, 32'h1, 32'h0);        // one coupon, forwards at once
    settle();
    set_config(csf_pkg::MODE_ELEM, 4'd8, 32'd0, 32'hFFFF_FFFF);
    send_request(32'h0000_00AA, 32'h2, 32'h0);        // nothing drawn
    settle();
    set_config(csf_pkg::MODE_ELEM, 4'd15, 32'h2000_0000, 32'd7);
    for (int i = 0; i < 8; i++) send_request(32'h0000_0077, $urandom, $urandom);
    settle();
    set_config(csf_pkg::MODE_ELEM, 4'd9, 32'h2000_0000, 32'd7);
    send_request(32'h0000_0077, $urandom, $urandom);
    settle();
    set_config(csf_pkg::MODE_ELEM, 4'd2, 32'h8000_0000, 32'd7);
    send_request(32'h0000_0077, $urandom, $urandom);
    settle();
  endtask

  // output held off long enough for the block to back up into its input
  task automatic test_output_backpressure();
    set_config(csf_pkg::MODE_RANDOM, 4'd3, 32'h5555_5555, $urandom);
    @(posedge clk_i);
    hold_req = 1'b1;
    @(negedge clk_i);
    for (int i = 0; i < 40; i++) send_request(flow_pool[i % 8], $urandom, $urandom);
    settle();
  endtask

  // random phases; most requests reuse a few flows so units fill and forward
  task automatic test_random_traffic();
    logic [3:0]  cnt;
    logic [31:0] step, flow;
    for (int p = 0; p < 7; p++) begin
      steady = (p == 3);
      cnt = 4'($urandom_range(0, 15));
      case ($urandom_range(0, 3))
        0:       step = 32'hFFFF_FFFF;
        1:       step = $urandom;
        default: step = 32'hFFFF_FFFF / ((cnt < 1) ? 1 : (cnt > 8) ? 8 : cnt);
      endcase
      set_config(2'($urandom_range(0, 3)), cnt, step,
                 (p == 0) ? 32'd0 : (p == 1) ? 32'hFFFF_FFFF : $urandom);
      for (int i = 0; i < 100; i++) begin
        flow = ($urandom_range(0, 99) < 80) ? flow_pool[$urandom_range(0, 7)] : $urandom;
        send_request(flow, $urandom, $urandom);
      end
      settle();
    end
    steady = 1'b0;
  endtask

  initial begin
    mode_q = csf_pkg::MODE_ELEM;
    count_q = 4'd4;
    step_q = 32'd429496729;
    seed_q = 32'd0;
    foreach (unit_store[i]) unit_store[i] = 8'd0;
    foreach (flow_pool[i]) flow_pool[i] = $urandom;
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    test_reset_defaults();
    test_hash_modes();
    test_coupon_edges();
    test_output_backpressure();
    test_random_traffic();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
